>>> rtl/atd_pkg.sv
// ----------------------------------------------------------------------------
// atd_pkg
// Shared types and constants of the adaptive touch detector.
// ----------------------------------------------------------------------------
`default_nettype none

package atd_pkg;

    // input beat fields
    typedef struct packed {
        logic        baseline_ok;
        logic [15:0] baseline_sample;
        logic        raw_ok;
        logic [15:0] raw_sample;
    } item_t;

    // detector decision handed from the tracker to the output stages
    typedef struct packed {
        logic       touching;
        logic [6:0] level;
    } det_t;

    localparam int THR_W       = 16;
    localparam int MARGIN_D_W  = 24;  // 65535 * 200 fits
    localparam int MARGIN_J_W  = 22;  // 65535 * 40 fits

    localparam logic [15:0] DEFAULT_DELTA    = 16'd100;
    localparam logic [7:0]  DELTA_GAIN       = 8'd200;
    localparam logic [7:0]  JUMP_GAIN        = 8'd40;
    localparam logic [MARGIN_D_W-1:0] DELTA_MARGIN_MIN = MARGIN_D_W'(2000);
    localparam logic [MARGIN_J_W-1:0] JUMP_MARGIN_MIN  = MARGIN_J_W'(1200);
    localparam int          JUMP_AVG_SHIFT   = 2;   // idle jump average times 4
    localparam logic [7:0]  RELEASE_HYST     = 8'd50;
    localparam int          LEVEL_EMA_SHIFT  = 4;
    localparam int          JUMP_EMA_SHIFT   = 3;
    localparam logic [1:0]  DEBOUNCE_SAMPLES = 2'd2;
    localparam logic [15:0] INTENSITY_SPAN   = 16'd1000;
    localparam logic [6:0]  LEVEL_MAX        = 7'd127;

    // floor(eff * 127 / 1000) for eff < 1000: (eff * LEVEL_RECIP) >> 20
    localparam logic [17:0] LEVEL_RECIP      = 18'd133170;
    localparam int          LEVEL_SHIFT      = 20;
    // floor(level * 100 / 127) for level <= 127: (level * PCT_RECIP) >> 16
    localparam logic [15:0] PCT_RECIP        = 16'd51604;
    localparam int          PCT_SHIFT        = 16;

endpackage

`default_nettype wire

>>> rtl/atd_track.sv
// ----------------------------------------------------------------------------
// atd_track
// Detector state: sample hold, idle averages, adaptive thresholds, debounce
// and intensity level. State advances on every load.
// ----------------------------------------------------------------------------
`default_nettype none

module atd_track #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               load,
    input  wire atd_pkg::item_t                     item,
    input  wire logic [atd_pkg::MARGIN_D_W-1:0]     margin_d,
    input  wire logic [atd_pkg::MARGIN_J_W-1:0]     margin_j,
    output atd_pkg::det_t                           det
);

    localparam int SB  = SAMPLE_BITS;
    localparam int SB1 = SAMPLE_BITS + 1;
    localparam int TW  = 25;
    localparam logic [SB-1:0] SMAX = {SB{1'b1}};

    logic          touch_reg, touch_next;
    logic [1:0]    flip_reg, flip_next;
    logic [SB-1:0] last_raw_reg, last_base_reg;
    logic [SB-1:0] avg_lvl_reg, avg_lvl_next;
    logic [SB-1:0] avg_jmp_reg, avg_jmp_next;

    logic [SB-1:0] cur, prev, base, jump, distance;
    logic [SB-1:0] on_d, on_j, off_d, off_j, eff;
    logic [15:0]   eff_w;
    logic [27:0]   lvl_prod;
    logic [1:0]    flip_inc;
    logic          instant;
    logic [6:0]    level;

    function automatic logic [SB-1:0] sat_in(input logic [15:0] v);
        if (v > 16'(SMAX)) return SMAX;
        return SB'(v);
    endfunction

    function automatic logic [SB-1:0] sat_thr(input logic [TW-1:0] v);
        if (v > TW'(SMAX)) return SMAX;
        return SB'(v);
    endfunction

    function automatic logic [SB-1:0] absd(input logic [SB-1:0] a, input logic [SB-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // avg + floor((target - avg) / 2^sh)
    function automatic logic [SB-1:0] ema(input logic [SB-1:0] avg,
                                          input logic [SB-1:0] target, input int sh);
        logic [SB1-1:0] d;
        logic [SB1-1:0] m;
        m = SB1'((1 << sh) - 1);
        if (target >= avg) begin
            d = {1'b0, target} - {1'b0, avg};
            return avg + SB'(d >> sh);
        end
        d = {1'b0, avg} - {1'b0, target} + m;
        return avg - SB'(d >> sh);
    endfunction

    function automatic logic [SB-1:0] off_of(input logic [SB-1:0] on);
        if (on > SB'(atd_pkg::RELEASE_HYST)) return on - SB'(atd_pkg::RELEASE_HYST);
        return on >> 1;
    endfunction

    always_comb begin
        cur  = item.raw_ok ? sat_in(item.raw_sample) : last_raw_reg;
        prev = (last_raw_reg == '0) ? cur : last_raw_reg;
        jump = absd(cur, prev);
        base = item.baseline_ok ? sat_in(item.baseline_sample) : last_base_reg;
        distance = absd(cur, base);

        // averages only follow the idle floor
        avg_lvl_next = touch_reg ? avg_lvl_reg
                                 : ema(avg_lvl_reg, distance, atd_pkg::LEVEL_EMA_SHIFT);
        avg_jmp_next = touch_reg ? avg_jmp_reg : ema(avg_jmp_reg, jump, atd_pkg::JUMP_EMA_SHIFT);

        on_d  = sat_thr(TW'(avg_lvl_next) + TW'(margin_d));
        on_j  = sat_thr((TW'(avg_jmp_next) << atd_pkg::JUMP_AVG_SHIFT) + TW'(margin_j));
        off_d = off_of(on_d);
        off_j = off_of(on_j);

        if (touch_reg) instant = (distance >= off_d) || (jump >= off_j);
        else           instant = (distance >= on_d)  || (jump >= on_j);

        flip_inc   = flip_reg + 2'd1;
        touch_next = touch_reg;
        flip_next  = 2'd0;
        if (instant != touch_reg) begin
            if (flip_inc >= atd_pkg::DEBOUNCE_SAMPLES) begin
                touch_next = instant;
            end else begin
                flip_next = flip_inc;
            end
        end

        eff      = (distance > off_d) ? (distance - off_d) : '0;
        eff_w    = 16'(eff);
        lvl_prod = 28'(eff_w[9:0]) * 28'(atd_pkg::LEVEL_RECIP);
        if (!touch_next)                           level = 7'd0;
        else if (eff_w >= atd_pkg::INTENSITY_SPAN) level = atd_pkg::LEVEL_MAX;
        else level = lvl_prod[atd_pkg::LEVEL_SHIFT +: 7];

        det.touching = touch_next;
        det.level    = level;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            touch_reg     <= 1'b0;
            flip_reg      <= 2'd0;
            last_raw_reg  <= '0;
            last_base_reg <= '0;
            avg_lvl_reg   <= '0;
            avg_jmp_reg   <= '0;
        end else if (load) begin
            touch_reg     <= touch_next;
            flip_reg      <= flip_next;
            last_raw_reg  <= cur;
            last_base_reg <= base;
            avg_lvl_reg   <= avg_lvl_next;
            avg_jmp_reg   <= avg_jmp_next;
        end
    end

    // debounce count clears on the second disagreeing sample
    a_flip_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !flip_reg[1])
        else $error("flip count reached debounce limit");

endmodule

`default_nettype wire

>>> rtl/adaptive_touch_detector.sv
// ----------------------------------------------------------------------------
// adaptive_touch_detector
// Capacitive touch decision with adaptive thresholds, hysteresis, debounce.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat per sensor sample (touch reading, baseline, flags).
//   m_ channel: one beat per sample: touching flag, level 0..127, percent.
//   cfg channel: writes the base sensitivity (touch_threshold); zero means
//   100. Write only while no sample is in flight. cfg_ready is always high.
// Timing:
//   Three register stages: input register, detector (state update and level),
//   percent stage / output register. A sample beat passes through the input
//   and detector registers before m_tvalid rises; one sample per cycle is
//   sustained while m_tready is high, as the detector updates its state once
//   per sample in the detector stage.
// Reset (aresetn low, synchronous): clears all tracking state, the debounce
//   and the pipeline; threshold returns to 100.
// Stall: when m_tready is low, beats wait in the pipeline registers; s_tready
//   drops only once all three stages hold a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_touch_detector #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] raw_sample, [16] raw_ok, [32:17] baseline_sample,
    // [33] baseline_ok, [39:34] zero
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] touching, [7:1] level, [14:8] percent, [15] zero
    output logic [15:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    logic                              in_valid_reg;
    atd_pkg::item_t                    in_item_reg;
    logic                              mid_valid_reg;
    atd_pkg::det_t                     mid_det_reg;
    logic                              out_valid_reg;
    logic [15:0]                       out_data_reg;
    logic [atd_pkg::MARGIN_D_W-1:0]    margin_d_reg, margin_d_next;
    logic [atd_pkg::MARGIN_J_W-1:0]    margin_j_reg, margin_j_next;

    logic [atd_pkg::THR_W-1:0]         th_eff;
    logic [atd_pkg::MARGIN_D_W-1:0]    md_prod;
    logic [atd_pkg::MARGIN_J_W-1:0]    mj_prod;
    atd_pkg::item_t                    s_item;
    atd_pkg::det_t                     det;
    logic                              out_load, mid_free, comp_load;
    logic [22:0]                       pct_prod;
    logic [6:0]                        percent;

    assign s_item.raw_sample      = s_tdata[15:0];
    assign s_item.raw_ok          = s_tdata[16];
    assign s_item.baseline_sample = s_tdata[32:17];
    assign s_item.baseline_ok     = s_tdata[33];

    assign out_load  = mid_valid_reg && (!out_valid_reg || m_tready);
    assign mid_free  = !mid_valid_reg || out_load;
    assign comp_load = in_valid_reg && mid_free;
    assign s_tready  = !in_valid_reg || comp_load;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // threshold margins are precomputed on the write
    always_comb begin
        th_eff  = (cfg_data == '0) ? atd_pkg::DEFAULT_DELTA : cfg_data;
        md_prod = atd_pkg::MARGIN_D_W'(th_eff) * atd_pkg::MARGIN_D_W'(atd_pkg::DELTA_GAIN);
        mj_prod = atd_pkg::MARGIN_J_W'(th_eff) * atd_pkg::MARGIN_J_W'(atd_pkg::JUMP_GAIN);
        margin_d_next = (md_prod > atd_pkg::DELTA_MARGIN_MIN) ? md_prod
                                                              : atd_pkg::DELTA_MARGIN_MIN;
        margin_j_next = (mj_prod > atd_pkg::JUMP_MARGIN_MIN) ? mj_prod
                                                             : atd_pkg::JUMP_MARGIN_MIN;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // margins for the default sensitivity of 100
            margin_d_reg <= atd_pkg::MARGIN_D_W'(atd_pkg::DEFAULT_DELTA)
                            * atd_pkg::MARGIN_D_W'(atd_pkg::DELTA_GAIN);
            margin_j_reg <= atd_pkg::MARGIN_J_W'(atd_pkg::DEFAULT_DELTA)
                            * atd_pkg::MARGIN_J_W'(atd_pkg::JUMP_GAIN);
        end else if (cfg_valid) begin
            margin_d_reg <= margin_d_next;
            margin_j_reg <= margin_j_next;
        end
    end

    atd_track #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_track (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (comp_load),
        .item     (in_item_reg),
        .margin_d (margin_d_reg),
        .margin_j (margin_j_reg),
        .det      (det)
    );

    always_comb begin
        pct_prod = 23'(mid_det_reg.level) * 23'(atd_pkg::PCT_RECIP);
        percent  = pct_prod[atd_pkg::PCT_SHIFT +: 7];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready)            in_valid_reg  <= s_tvalid;
            if (mid_free)            mid_valid_reg <= comp_load;
            if (!out_valid_reg || m_tready) out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) in_item_reg  <= s_item;
        if (comp_load)            mid_det_reg  <= det;
        if (out_load)             out_data_reg <= {1'b0, percent, mid_det_reg.level,
                                                   mid_det_reg.touching};
    end

    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_data_reg[0] |-> out_data_reg[14:1] == '0)
        else $error("level or percent set while not touching");

    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_data_reg[14:8] <= 7'd100 && !out_data_reg[15])
        else $error("percent out of range");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !s_tready |-> mid_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled with room downstream");

    a_mid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        mid_valid_reg && !out_load |=> mid_valid_reg && $stable(mid_det_reg))
        else $error("detector result lost while output stalled");

endmodule

`default_nettype wire
